FILE: src/spq_pkg.sv
`timescale 1ns / 1ps
package spq_pkg;

  localparam int unsigned VAL_W = 32;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] removed_value;
    logic [3:0]              entries_now;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [VAL_W-1:0] wdata;
  } mem_wr_t;

endpackage

FILE: src/spq_mem.sv
`timescale 1ns / 1ps
module spq_mem
  import spq_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  mem_wr_t          wr,
  input  logic [AW-1:0]    waddr,
  input  logic [AW-1:0]    raddr,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/spq_ctrl.sv
`timescale 1ns / 1ps
module spq_ctrl
  import spq_pkg::*;
#(
  parameter int CAPACITY = 8,
  parameter int AW       = 3,
  parameter int CW       = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_req_type,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    out_free,
  output logic                    emit,
  output result_t                 emit_res,
  output mem_wr_t                 mem_wr,
  output logic [AW-1:0]           mem_waddr,
  output logic [AW-1:0]           mem_raddr,
  input  logic [VAL_W-1:0]        mem_rdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INS    = 3'd1;
  localparam logic [2:0] S_PUT    = 3'd2;
  localparam logic [2:0] S_DEL    = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  result_t          res_r, res_nxt;

  logic             fin;
  logic [1:0]       fin_status;
  logic [VAL_W-1:0] fin_removed;
  logic [CW-1:0]    fin_count;
  logic [CW+3:0]    fin_count_ext;
  result_t          fin_res;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [AW-1:0] k);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, k};
    if (s >= (AW+1)'(CAPACITY)) begin
      s = s - (AW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  assign in_stall      = (state_r != S_IDLE);
  assign fin_count_ext = {4'b0, fin_count};

  always_comb begin
    fin_res.status        = fin_status;
    fin_res.removed_value = fin_removed;
    fin_res.entries_now   = fin_count_ext[3:0];
  end

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    res_nxt     = res_r;
    mem_wr.we    = 1'b0;
    mem_wr.wdata = val_r;
    mem_waddr   = head_r;
    mem_raddr   = head_r;
    fin         = 1'b0;
    fin_status  = STATUS_OK;
    fin_removed = '0;
    fin_count   = count_r;
    emit        = 1'b0;
    emit_res    = res_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_INSERT) begin
            if (count_r == CNT_FULL) begin
              fin        = 1'b1;
              fin_status = STATUS_OVERFLOW;
            end else if (count_r == '0) begin
              mem_wr.we    = 1'b1;
              mem_wr.wdata = in_value;
              mem_waddr    = head_r;
              count_nxt    = count_r + 1'b1;
              fin          = 1'b1;
              fin_count    = count_r + 1'b1;
            end else begin
              val_nxt   = in_value;
              pos_nxt   = count_r[AW-1:0];
              mem_raddr = wrap(head_r, count_r[AW-1:0] - 1'b1);
              state_nxt = S_INS;
            end
          end else begin
            if (count_r == '0) begin
              fin        = 1'b1;
              fin_status = STATUS_UNDERFLOW;
            end else begin
              mem_raddr = head_r;
              state_nxt = S_DEL;
            end
          end
        end
      end
      S_INS: begin
        mem_wr.we = 1'b1;
        mem_waddr = wrap(head_r, pos_r);
        if ($signed(mem_rdata) <= $signed(val_r)) begin
          mem_wr.wdata = val_r;
          count_nxt    = count_r + 1'b1;
          fin          = 1'b1;
          fin_count    = count_r + 1'b1;
        end else begin
          mem_wr.wdata = mem_rdata;
          pos_nxt      = pos_r - 1'b1;
          if (pos_r == AW'(1)) begin
            state_nxt = S_PUT;
          end else begin
            mem_raddr = wrap(head_r, pos_r - AW'(2));
          end
        end
      end
      S_PUT: begin
        mem_wr.we    = 1'b1;
        mem_wr.wdata = val_r;
        mem_waddr    = head_r;
        count_nxt    = count_r + 1'b1;
        fin          = 1'b1;
        fin_count    = count_r + 1'b1;
      end
      S_DEL: begin
        head_nxt    = wrap(head_r, AW'(1));
        count_nxt   = count_r - 1'b1;
        fin         = 1'b1;
        fin_removed = mem_rdata;
        fin_count   = count_r - 1'b1;
      end
      S_RESULT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_res  = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        emit      = 1'b1;
        emit_res  = fin_res;
        state_nxt = S_IDLE;
      end else begin
        res_nxt   = fin_res;
        state_nxt = S_RESULT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    res_r <= res_nxt;
  end

endmodule

FILE: src/sorted_priority_queue.sv
`timescale 1ns / 1ps
// sorted priority queue of signed 32-bit values, smallest first
// input channel: in_valid / in_stall with in_req_type (0 insert, 1 delete)
//   and in_value; a word is taken when in_valid is high and in_stall low
// result channel: out_valid / out_stall with out_status, out_removed_value
//   and out_entries_now; exactly one result word per request, in order
// entries live in a circular buffer in one synchronous ram (one read and
//   one write port); a delete reads the head and advances it
// an insert walks down from the tail, one ram read and one shifted write
//   per cycle, until it finds its slot
// overflow, underflow and insert into an empty queue finish in the idle state;
//   a delete finishes after the head read; other inserts end with the ram read loop
// a new request is taken once the previous one has finished its ram work,
//   even while its result still waits in the output register
// if the receiver stalls and the output register is full, the next result
//   is held inside and no further request is taken until it moves on
// reset (synchronous, rst_n low) empties the queue; ram contents are not
//   cleared, no clearing pass is needed
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_req_type,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_removed_value,
  output logic [3:0]              out_entries_now
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic             out_valid_r;
  result_t          out_res_r;
  logic             out_free;
  logic             emit;
  result_t          emit_res;
  mem_wr_t          mem_wr;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  assign out_free = !out_valid_r || !out_stall;

  spq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_value    (in_value),
    .out_free    (out_free),
    .emit        (emit),
    .emit_res    (emit_res),
    .mem_wr      (mem_wr),
    .mem_waddr   (mem_waddr),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  spq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .waddr (mem_waddr),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res_r <= emit_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_removed_value = out_res_r.removed_value;
  assign out_entries_now   = out_res_r.entries_now;

endmodule

FILE: tb/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int QCAP = 8;
  localparam int HALF_PERIOD = 4;
  localparam int STALL_LIMIT = 1000;
  localparam int ITEMS_PER_PROFILE = 488;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  class pq_scoreboard;
    logic signed [VAL_W-1:0] held [QCAP];
    int unsigned held_n;
    result_t expected [$];
    int errors;
    int checked;
    int overflows;
    int underflows;

    function new();
      held_n = 0;
      errors = 0;
      checked = 0;
      overflows = 0;
      underflows = 0;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    // sorted insert after every entry <= value, delete pops slot 0
    function void note_request(logic req, logic signed [VAL_W-1:0] val);
      result_t r;
      int pos;
      r.status = STATUS_OK;
      r.removed_value = '0;
      if (req == REQ_INSERT) begin
        if (held_n >= QCAP) begin
          r.status = STATUS_OVERFLOW;
        end else begin
          pos = held_n;
          while (pos > 0 && held[pos-1] > val) begin
            held[pos] = held[pos-1];
            pos--;
          end
          held[pos] = val;
          held_n++;
        end
      end else begin
        if (held_n == 0) begin
          r.status = STATUS_UNDERFLOW;
        end else begin
          r.removed_value = held[0];
          for (int k = 1; k < held_n; k++) held[k-1] = held[k];
          held_n--;
        end
      end
      r.entries_now = held_n[3:0];
      expected.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic signed [VAL_W-1:0] rv, logic [3:0] en);
      result_t e;
      if (expected.size() == 0) begin
        $display("%0t: result word with nothing expected: status %0d value %0d count %0d",
                 $time, st, rv, en);
        errors++;
        return;
      end
      e = expected.pop_front();
      checked++;
      if (e.status == STATUS_OVERFLOW) overflows++;
      if (e.status == STATUS_UNDERFLOW) underflows++;
      if (st !== e.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (rv !== e.removed_value) begin
        $display("%0t: removed_value mismatch: expected %0d actual %0d",
                 $time, e.removed_value, rv);
        errors++;
      end
      if (en !== e.entries_now) begin
        $display("%0t: entries_now mismatch: expected %0d actual %0d",
                 $time, e.entries_now, en);
        errors++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_req_type = REQ_INSERT;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [1:0]              out_status;
  logic signed [VAL_W-1:0] out_removed_value;
  logic [3:0]              out_entries_now;

  pq_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int n_sent = 0;
  int quiet_cycles = 0;

  sorted_priority_queue #(.CAPACITY(QCAP)) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_entries_now   (out_entries_now)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_status, out_removed_value, out_entries_now);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_request(input logic req, input logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_value    <= val;
    do @(posedge clk); while (in_stall);
    sb.note_request(req, val);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (QCAP + 4) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = '0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      1, 2, 3: v = $signed($urandom_range(6)) - 3;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // bursts leaning toward fill or drain, or balanced, so full and empty come up often
  task automatic random_burst(input int count);
    int left;
    int run;
    int ins_pct;
    left = count;
    while (left > 0) begin
      run = $urandom_range(24, 8);
      if (run > left) run = left;
      case ($urandom_range(2))
        0: ins_pct = 85;
        1: ins_pct = 15;
        default: ins_pct = 50;
      endcase
      repeat (run) begin
        if ($urandom_range(99) < ins_pct) push_request(REQ_INSERT, pick_value());
        else push_request(REQ_DELETE, $urandom);
      end
      left -= run;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, equal values, fill to overflow, empty to underflow
    push_request(REQ_DELETE, VAL_MAX);
    push_request(REQ_INSERT, VAL_MAX);
    push_request(REQ_INSERT, VAL_MIN);
    push_request(REQ_INSERT, 0);
    push_request(REQ_INSERT, -1);
    push_request(REQ_INSERT, 5);
    push_request(REQ_INSERT, 5);
    push_request(REQ_INSERT, 1);
    push_request(REQ_INSERT, -5);
    push_request(REQ_INSERT, 100);
    push_request(REQ_INSERT, VAL_MIN);
    repeat (QCAP) push_request(REQ_DELETE, VAL_MIN);
    push_request(REQ_DELETE, -1);
    push_request(REQ_INSERT, VAL_MIN);
    push_request(REQ_INSERT, VAL_MIN);
    push_request(REQ_DELETE, 0);
    push_request(REQ_DELETE, 0);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      random_burst(ITEMS_PER_PROFILE / 2);
      if (p == 2) wait_drained();
      random_burst(ITEMS_PER_PROFILE - ITEMS_PER_PROFILE / 2);
    end

    wait_drained();
    $display("sent %0d requests, checked %0d result words", n_sent, sb.checked);
    $display("hit %0d overflows and %0d underflows across four idle/stall profiles",
             sb.overflows, sb.underflows);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
